### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with an active-low disable, used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never shows at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Widths, codes and shared types of the time-weighted sample statistics block.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam int VALUE_BITS  = 16;
	localparam int DUR_BITS    = 24;
	localparam int SUM_BITS    = 26;
	localparam int SCOUNT_BITS = 11;
	localparam int COUNT_BITS  = 21;
	localparam int WSUM_BITS   = 60;
	localparam int TDUR_BITS   = 44;
	localparam int PROD_BITS   = VALUE_BITS + DUR_BITS;
	localparam int STATUS_BITS = 2;

	// shared divider: widest job is the weighted mean
	localparam int DIV_NUM_BITS  = WSUM_BITS + 1;
	localparam int DIV_DEN_BITS  = TDUR_BITS;
	localparam int DIV_CNT_BITS  = $clog2(DIV_NUM_BITS + 1);
	localparam int MEAN_NUM_BITS = SUM_BITS + 1;
	localparam int VF_NUM_BITS   = COUNT_BITS + VALUE_BITS;

	// queue between front and back
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	// configuration
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_USE_MAX   = 4'd1;

	// result status
	localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_ZERO_DUR = 2'd2;

	// one record handed from front to back
	typedef struct packed {
		logic                   close;
		logic                   last;
		logic                   empty;
		logic [SUM_BITS-1:0]    sum;
		logic [SCOUNT_BITS-1:0] count;
		logic [VALUE_BITS-1:0]  peak;
		logic [DUR_BITS-1:0]    dur;
		logic [VALUE_BITS-1:0]  min_v;
		logic [VALUE_BITS-1:0]  max_v;
		logic [COUNT_BITS-1:0]  viol;
		logic [COUNT_BITS-1:0]  tot;
	} tws_entry_t;

	typedef struct packed {
		logic valid;
		logic full;
	} tws_q_status_t;

	typedef struct packed {
		logic                    start;
		logic [DIV_NUM_BITS-1:0] num;
		logic [DIV_DEN_BITS-1:0] den;
		logic [DIV_CNT_BITS-1:0] nbits;
	} tws_div_req_t;

	typedef struct packed {
		logic                    done;
		logic [DIV_NUM_BITS-1:0] quo;
	} tws_div_rsp_t;

endpackage

### rtl/tws_if.sv
// ----------------------------------------------------------------------------
// tws channel interfaces
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
interface tws_item_if import tws_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic [DUR_BITS-1:0]   sample_duration;
	logic                  empty_sample;
	logic                  sample_end;
	logic                  set_end;

	modport source(output valid, value, sample_duration, empty_sample, sample_end, set_end,
		input ready);
	modport sink(input valid, value, sample_duration, empty_sample, sample_end, set_end,
		output ready);
endinterface

interface tws_result_if import tws_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_BITS-1:0]  min_value;
	logic [VALUE_BITS-1:0]  max_value;
	logic [VALUE_BITS-1:0]  weighted_metric;
	logic [VALUE_BITS-1:0]  violation_fraction;
	logic [STATUS_BITS-1:0] status;

	modport source(output valid, min_value, max_value, weighted_metric, violation_fraction,
		status, input ready);
	modport sink(input valid, min_value, max_value, weighted_metric, violation_fraction,
		status, output ready);
endinterface

interface tws_cfg_if import tws_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/tws_front.sv
// ----------------------------------------------------------------------------
// tws_front
// Accept items, keep per-value statistics, emit sample and set records.
// ----------------------------------------------------------------------------
module tws_front import tws_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	tws_item_if.sink      items,
	tws_cfg_if.sink       cfg,
	input  tws_q_status_t q_status,
	output logic          push,
	output tws_entry_t    push_entry,
	output logic          use_max
);

	localparam logic [SCOUNT_BITS-1:0] SCOUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

	logic [VALUE_BITS-1:0]  threshold_q;
	logic                   use_max_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [SCOUNT_BITS-1:0] scount_q;
	logic [VALUE_BITS-1:0]  peak_q;
	logic [VALUE_BITS-1:0]  min_q;
	logic [VALUE_BITS-1:0]  max_q;
	logic [COUNT_BITS-1:0]  viol_q;
	logic [COUNT_BITS-1:0]  tot_q;
	logic                   empty_q;

	logic                   fire;
	logic                   close;
	logic [SUM_BITS:0]      sum_wide;
	logic [SUM_BITS-1:0]    sum_n;
	logic [SCOUNT_BITS-1:0] scount_n;
	logic [VALUE_BITS-1:0]  peak_n;
	logic [VALUE_BITS-1:0]  min_n;
	logic [VALUE_BITS-1:0]  max_n;
	logic [COUNT_BITS-1:0]  viol_n;
	logic [COUNT_BITS-1:0]  tot_n;
	logic                   empty_n;

	assign cfg.ready   = 1'b1;
	assign items.ready = !q_status.full;
	assign fire        = items.valid && items.ready;
	assign use_max     = use_max_q;

	always_comb begin
		sum_wide = {1'b0, sum_q} + (SUM_BITS + 1)'(items.value);
		sum_n    = sum_q;
		scount_n = scount_q;
		peak_n   = peak_q;
		min_n    = min_q;
		max_n    = max_q;
		viol_n   = viol_q;
		tot_n    = tot_q;
		empty_n  = empty_q;
		if (items.empty_sample) begin
			empty_n = 1'b1;
		end else begin
			min_n    = (items.value < min_q) ? items.value : min_q;
			max_n    = (items.value > max_q) ? items.value : max_q;
			peak_n   = (items.value > peak_q) ? items.value : peak_q;
			tot_n    = (tot_q == COUNT_MAX) ? tot_q : tot_q + 1'b1;
			scount_n = (scount_q == SCOUNT_MAX) ? scount_q : scount_q + 1'b1;
			sum_n    = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
			if (items.value > threshold_q) begin
				viol_n = (viol_q == COUNT_MAX) ? viol_q : viol_q + 1'b1;
			end
		end
		close = (items.sample_end || items.set_end) && (scount_n != '0);
	end

	assign push = fire && (close || items.set_end);

	always_comb begin
		push_entry.close = close;
		push_entry.last  = items.set_end;
		push_entry.empty = empty_n;
		push_entry.sum   = sum_n;
		push_entry.count = scount_n;
		push_entry.peak  = peak_n;
		push_entry.dur   = items.sample_duration;
		push_entry.min_v = min_n;
		push_entry.max_v = max_n;
		push_entry.viol  = viol_n;
		push_entry.tot   = tot_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			use_max_q   <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == CFG_THRESHOLD) begin
				threshold_q <= cfg.data[VALUE_BITS-1:0];
			end else if (cfg.index == CFG_USE_MAX) begin
				use_max_q <= cfg.data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			scount_q <= '0;
			peak_q   <= '0;
			min_q    <= '1;
			max_q    <= '0;
			viol_q   <= '0;
			tot_q    <= '0;
			empty_q  <= 1'b0;
		end else if (fire) begin
			if (items.set_end) begin
				// set done: start over
				sum_q    <= '0;
				scount_q <= '0;
				peak_q   <= '0;
				min_q    <= '1;
				max_q    <= '0;
				viol_q   <= '0;
				tot_q    <= '0;
				empty_q  <= 1'b0;
			end else begin
				min_q   <= min_n;
				max_q   <= max_n;
				viol_q  <= viol_n;
				tot_q   <= tot_n;
				empty_q <= empty_n;
				if (close) begin
					sum_q    <= '0;
					scount_q <= '0;
					peak_q   <= '0;
				end else begin
					sum_q    <= sum_n;
					scount_q <= scount_n;
					peak_q   <= peak_n;
				end
			end
		end
	end

endmodule

### rtl/tws_queue.sv
// ----------------------------------------------------------------------------
// tws_queue
// Short record queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module tws_queue import tws_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tws_entry_t    push_entry,
	input  logic          pop,
	output tws_entry_t    head,
	output tws_q_status_t q_status
);

	tws_entry_t            slot_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_CNT_BITS-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign q_status.valid = (count_q != '0);
	assign q_status.full  = (count_q == Q_CNT_BITS'(Q_DEPTH));
	assign do_push        = push && !q_status.full;
	assign do_pop         = pop && q_status.valid;
	assign head           = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/tws_div.sv
// ----------------------------------------------------------------------------
// tws_div
// Radix-2 restoring divider, one quotient bit per cycle, left-aligned input.
// ----------------------------------------------------------------------------
module tws_div import tws_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  tws_div_req_t req,
	output tws_div_rsp_t rsp
);

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [DIV_DEN_BITS-1:0] den_q;
	logic [DIV_DEN_BITS-1:0] rem_q;
	logic [DIV_NUM_BITS-1:0] quo_q;

	logic [DIV_DEN_BITS:0]   trial;
	logic                    fits;
	logic [DIV_DEN_BITS-1:0] rem_n;

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_comb begin
		trial = {rem_q, quo_q[DIV_NUM_BITS-1]};
		fits  = (trial >= {1'b0, den_q});
		rem_n = fits ? DIV_DEN_BITS'(trial - {1'b0, den_q}) : trial[DIV_DEN_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[DIV_NUM_BITS-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/tws_back.sv
// ----------------------------------------------------------------------------
// tws_back
// Weight closed samples by duration, and finish a set into one result beat.
// ----------------------------------------------------------------------------
module tws_back import tws_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          use_max,
	input  tws_entry_t    head,
	input  tws_q_status_t q_status,
	output logic          pop,
	tws_result_if.source  results
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MEAN = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_WM   = 3'd5;
	localparam logic [2:0] ST_VF   = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	localparam logic [VALUE_BITS-1:0] OUT_MAX = '1;

	logic [2:0]            state_q;
	tws_entry_t            ent_q;
	logic [VALUE_BITS-1:0] elem_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic [WSUM_BITS-1:0]  wsum_q;
	logic [TDUR_BITS-1:0]  tdur_q;
	logic [VALUE_BITS-1:0] wm_q;
	logic [VALUE_BITS-1:0] vf_q;

	logic                   res_valid_q;
	logic [VALUE_BITS-1:0]  res_min_q;
	logic [VALUE_BITS-1:0]  res_max_q;
	logic [VALUE_BITS-1:0]  res_wm_q;
	logic [VALUE_BITS-1:0]  res_vf_q;
	logic [STATUS_BITS-1:0] res_status_q;

	tws_div_req_t div_req;
	tws_div_rsp_t div_rsp;

	logic [MEAN_NUM_BITS-1:0] mean_num;
	logic [DIV_NUM_BITS-1:0]  wm_num;
	logic [WSUM_BITS:0]       wsum_wide;
	logic [TDUR_BITS:0]       tdur_wide;
	logic [VALUE_BITS-1:0]    quo_clamped;
	logic                     zero_dur;
	logic                     out_load;

	tws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign mean_num    = {1'b0, head.sum} + MEAN_NUM_BITS'(head.count >> 1);
	assign wm_num      = {1'b0, wsum_q} + DIV_NUM_BITS'(tdur_q >> 1);
	assign wsum_wide   = {1'b0, wsum_q} + (WSUM_BITS + 1)'(prod_q);
	assign tdur_wide   = {1'b0, tdur_q} + (TDUR_BITS + 1)'(ent_q.dur);
	assign quo_clamped = (|div_rsp.quo[DIV_NUM_BITS-1:VALUE_BITS]) ? OUT_MAX
		: div_rsp.quo[VALUE_BITS-1:0];
	assign zero_dur    = (tdur_q == '0);
	assign out_load    = (state_q == ST_OUT) && (!res_valid_q || results.ready);
	assign pop         = (state_q == ST_IDLE) && q_status.valid;

	// launch the shared divider; operands are left-aligned in its numerator
	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_status.valid && head.close && !use_max) begin
					div_req.start = 1'b1;
					div_req.num   = {mean_num, (DIV_NUM_BITS - MEAN_NUM_BITS)'(0)};
					div_req.den   = DIV_DEN_BITS'(head.count);
					div_req.nbits = DIV_CNT_BITS'(MEAN_NUM_BITS);
				end
			end
			ST_FIN: begin
				if (!ent_q.empty && !zero_dur) begin
					div_req.start = 1'b1;
					div_req.num   = wm_num;
					div_req.den   = tdur_q;
					div_req.nbits = DIV_CNT_BITS'(DIV_NUM_BITS);
				end
			end
			ST_WM: begin
				if (div_rsp.done && ent_q.tot != '0) begin
					div_req.start = 1'b1;
					div_req.num   = {ent_q.viol, (VALUE_BITS)'(0),
						(DIV_NUM_BITS - VF_NUM_BITS)'(0)};
					div_req.den   = DIV_DEN_BITS'(ent_q.tot);
					div_req.nbits = DIV_CNT_BITS'(VF_NUM_BITS);
				end
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_status.valid) begin
					ent_q <= head;
					if (head.close && use_max) begin
						elem_q <= head.peak;
					end
				end
			end
			ST_MEAN: begin
				if (div_rsp.done) begin
					elem_q <= div_rsp.quo[VALUE_BITS-1:0];
				end
			end
			ST_MUL: begin
				prod_q <= elem_q * ent_q.dur;
			end
			ST_WM: begin
				if (div_rsp.done) begin
					wm_q <= quo_clamped;
					vf_q <= '0;
				end
			end
			ST_VF: begin
				if (div_rsp.done) begin
					vf_q <= quo_clamped;
				end
			end
			default: begin
				elem_q <= elem_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wsum_q  <= '0;
			tdur_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_status.valid) begin
						if (head.close) begin
							state_q <= use_max ? ST_MUL : ST_MEAN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MEAN: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					wsum_q  <= wsum_wide[WSUM_BITS] ? '1 : wsum_wide[WSUM_BITS-1:0];
					tdur_q  <= tdur_wide[TDUR_BITS] ? '1 : tdur_wide[TDUR_BITS-1:0];
					state_q <= ent_q.last ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					state_q <= (ent_q.empty || zero_dur) ? ST_OUT : ST_WM;
				end
				ST_WM: begin
					if (div_rsp.done) begin
						state_q <= (ent_q.tot == '0) ? ST_OUT : ST_VF;
					end
				end
				ST_VF: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						wsum_q  <= '0;
						tdur_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: hold the beat until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_min_q <= '0;
			res_max_q <= '0;
			res_wm_q  <= '0;
			res_vf_q  <= '0;
			priority if (ent_q.empty) begin
				res_status_q <= STATUS_EMPTY;
			end else if (zero_dur) begin
				res_status_q <= STATUS_ZERO_DUR;
			end else begin
				res_status_q <= STATUS_OK;
				res_min_q    <= ent_q.min_v;
				res_max_q    <= ent_q.max_v;
				res_wm_q     <= wm_q;
				res_vf_q     <= vf_q;
			end
		end
	end

	assign results.valid              = res_valid_q;
	assign results.min_value          = res_min_q;
	assign results.max_value          = res_max_q;
	assign results.weighted_metric    = res_wm_q;
	assign results.violation_fraction = res_vf_q;
	assign results.status             = res_status_q;

endmodule

### rtl/time_weighted_sample_statistics.sv
// ----------------------------------------------------------------------------
// time_weighted_sample_statistics
// Running min/max, violation fraction and duration-weighted mean over a set.
// ----------------------------------------------------------------------------
// The block takes one Q0.16 value beat per cycle on items and answers every
// set_end with exactly one beat on results. The front takes a beat in every
// cycle while the four-record queue has room; only beats that close a sample
// or end a set enter the queue. The back runs a closed sample through its
// MUL and ACC states, after a MEAN state on the shared one-bit-per-cycle
// divider (27-bit quotient) in mean mode, and finishes a set with a 61-bit
// divide for the weighted metric, a 37-bit divide for the violation
// fraction, and the output load. So a stream sustains one value
// per cycle as long as samples carry enough values to hide the back's work
// per close; a burst of short samples fills the queue and items.ready drops
// until the back drains it. Configuration writes are taken in any cycle and
// must come only while the block is idle.
// ----------------------------------------------------------------------------
module time_weighted_sample_statistics import tws_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	tws_cfg_if.sink      cfg,
	tws_item_if.sink     items,
	tws_result_if.source results
);

	// front -> queue
	logic       push;
	tws_entry_t push_entry;

	// queue -> back
	logic          pop;
	tws_entry_t    head;
	tws_q_status_t q_status;

	// mode register lives with the configuration port in the front
	logic use_max;

	// Classify beats, keep the per-value statistics and write the registers.
	tws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.cfg        (cfg),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry),
		.use_max    (use_max)
	);

	// Hold closed-sample and set-end records until the back is free.
	tws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	// Weight samples, divide out the totals and drive the result beat.
	tws_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.use_max  (use_max),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.results  (results)
	);

endmodule

### rtl/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks on the result channel of the statistics block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tws_checker import tws_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [VALUE_BITS-1:0]  out_min,
	input logic [VALUE_BITS-1:0]  out_max,
	input logic [VALUE_BITS-1:0]  out_wm,
	input logic [VALUE_BITS-1:0]  out_vf,
	input logic [STATUS_BITS-1:0] out_status
);

	`ASSERT_AT(a_hold_valid, clk, arst_n,
		out_valid && !out_ready |=> out_valid,
		"result beat dropped while stalled")
	`ASSERT_AT(a_hold_data, clk, arst_n,
		out_valid && !out_ready |=> $stable(out_status) && $stable(out_wm)
		&& $stable(out_vf) && $stable(out_min) && $stable(out_max),
		"result beat changed while stalled")
	`ASSERT_NEVER(a_flag_zeros, clk, arst_n,
		out_valid && out_status != STATUS_OK
		&& (out_min != '0 || out_max != '0 || out_wm != '0 || out_vf != '0),
		"flagged result carries nonzero fields")
	`ASSERT_NEVER(a_min_le_max, clk, arst_n,
		out_valid && out_status == STATUS_OK && out_min > out_max,
		"valid result has min above max")

endmodule

bind time_weighted_sample_statistics tws_checker u_tws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_min    (results.min_value),
	.out_max    (results.max_value),
	.out_wm     (results.weighted_metric),
	.out_vf     (results.violation_fraction),
	.out_status (results.status)
);

### bench/time_weighted_sample_statistics_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_weighted_sample_statistics_tb
// Self-checking bench: a directed table of sets, then random sets under six
// register settings. Every accepted item beat runs through a local model of
// the statistics, and every result beat is compared field by field with the
// oldest predicted result.
// ----------------------------------------------------------------------------
module time_weighted_sample_statistics_tb;
	import tws_pkg::*;

	// run shape
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 300;  // longest back-end work: 4 mean closes plus a set
	localparam int HOLD_CYCLES   = 500;
	localparam int PHASE_ITEMS   = 70;
	localparam int N_PHASES      = 6;
	localparam int LONG_SAMPLE   = 1100; // past the 26-bit sum
	localparam int N_DIRECTED    = 19;

	localparam logic [VALUE_BITS-1:0] FULL     = '1;
	localparam logic [DUR_BITS-1:0]   DUR_FULL = '1;

	// register index that maps to nothing; the block must ignore it
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NONE = 4'hE;

	// saturation tops of the accumulators
	localparam logic [63:0] SUM_TOP    = (64'd1 << SUM_BITS) - 64'd1;
	localparam logic [63:0] SCOUNT_TOP = (64'd1 << SCOUNT_BITS) - 64'd1;
	localparam logic [63:0] COUNT_TOP  = (64'd1 << COUNT_BITS) - 64'd1;
	localparam logic [63:0] WSUM_TOP   = (64'd1 << WSUM_BITS) - 64'd1;
	localparam logic [63:0] TDUR_TOP   = (64'd1 << TDUR_BITS) - 64'd1;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [DUR_BITS-1:0]   dur;
		logic                  empty;
		logic                  s_end;
		logic                  set_end;
	} stats_item_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0]  min_v;
		logic [VALUE_BITS-1:0]  max_v;
		logic [VALUE_BITS-1:0]  wmetric;
		logic [VALUE_BITS-1:0]  vfrac;
		logic [STATUS_BITS-1:0] status;
	} stats_result_t;

	// one line of the directed table; fixed rows carry a hand-written result
	typedef struct packed {
		stats_item_t   it;
		logic          fixed;
		stats_result_t res;
	} directed_row_t;

	logic clk;
	logic arst_n;

	tws_cfg_if    cfg_bus();
	tws_item_if   item_bus();
	tws_result_if result_bus();

	time_weighted_sample_statistics uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.items  (item_bus),
		.results(result_bus)
	);

	// local copy of the registers
	logic [VALUE_BITS-1:0] thr_reg;
	logic                  max_mode;

	// local copy of the set state
	logic [63:0]           acc_sum;
	logic [63:0]           acc_cnt;
	logic [VALUE_BITS-1:0] acc_peak;
	logic [VALUE_BITS-1:0] set_min;
	logic [VALUE_BITS-1:0] set_max;
	logic [63:0]           viol_cnt;
	logic [63:0]           val_cnt;
	logic [63:0]           wsum;
	logic [63:0]           tdur;
	logic                  saw_empty;

	stats_result_t expected_stats[$];
	directed_row_t fixed_stats[$];
	directed_row_t directed_rows[N_DIRECTED];

	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int unsigned hold_requests;

	// ------------------------------------------------------------------------
	// Model of the statistics
	// ------------------------------------------------------------------------
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] top);
		if (a >= top || b > top - a)
			return top;
		return a + b;
	endfunction

	function automatic void stats_clear();
		acc_sum   = '0;
		acc_cnt   = '0;
		acc_peak  = '0;
		set_min   = '1;
		set_max   = '0;
		viol_cnt  = '0;
		val_cnt   = '0;
		wsum      = '0;
		tdur      = '0;
		saw_empty = 1'b0;
	endfunction

	// Advance the set state by one item; return 1 with the result on set end.
	function automatic bit stats_accept(input stats_item_t it, output stats_result_t res);
		logic [63:0] elem;
		logic [63:0] wm;
		logic [63:0] vf;
		res = '0;
		if (it.empty) begin
			saw_empty = 1'b1;
		end else begin
			if (it.value < set_min) set_min = it.value;
			if (it.value > set_max) set_max = it.value;
			val_cnt = sat_add(val_cnt, 64'd1, COUNT_TOP);
			if (it.value > thr_reg) viol_cnt = sat_add(viol_cnt, 64'd1, COUNT_TOP);
			acc_sum = sat_add(acc_sum, 64'(it.value), SUM_TOP);
			acc_cnt = sat_add(acc_cnt, 64'd1, SCOUNT_TOP);
			if (it.value > acc_peak) acc_peak = it.value;
		end

		// set end closes the open sample too, but only one that holds values
		if ((it.s_end || it.set_end) && acc_cnt != 0) begin
			if (max_mode)
				elem = 64'(acc_peak);
			else
				elem = (acc_sum + acc_cnt / 2) / acc_cnt;
			wsum     = sat_add(wsum, elem * 64'(it.dur), WSUM_TOP);
			tdur     = sat_add(tdur, 64'(it.dur), TDUR_TOP);
			acc_sum  = '0;
			acc_cnt  = '0;
			acc_peak = '0;
		end

		if (!it.set_end)
			return 1'b0;

		// an empty sample outranks a zero total duration
		if (saw_empty) begin
			res.status = STATUS_EMPTY;
		end else if (tdur == 0) begin
			res.status = STATUS_ZERO_DUR;
		end else begin
			wm = (wsum + tdur / 2) / tdur;
			vf = (val_cnt != 0) ? (viol_cnt << VALUE_BITS) / val_cnt : 64'd0;
			res.min_v   = set_min;
			res.max_v   = set_max;
			res.wmetric = (wm > 64'(FULL)) ? FULL : wm[VALUE_BITS-1:0];
			res.vfrac   = (vf > 64'(FULL)) ? FULL : vf[VALUE_BITS-1:0];
			res.status  = STATUS_OK;
		end
		stats_clear();
		return 1'b1;
	endfunction

	function automatic directed_row_t mk_row(input logic [VALUE_BITS-1:0] value,
		input logic [DUR_BITS-1:0] dur, input bit empty, input bit s_end, input bit set_end,
		input bit fixed, input logic [VALUE_BITS-1:0] min_v, input logic [VALUE_BITS-1:0] max_v,
		input logic [VALUE_BITS-1:0] wmetric, input logic [VALUE_BITS-1:0] vfrac,
		input logic [STATUS_BITS-1:0] status);
		directed_row_t r;
		r.it.value   = value;
		r.it.dur     = dur;
		r.it.empty   = empty;
		r.it.s_end   = s_end;
		r.it.set_end = set_end;
		r.fixed      = fixed;
		r.res.min_v   = min_v;
		r.res.max_v   = max_v;
		r.res.wmetric = wmetric;
		r.res.vfrac   = vfrac;
		r.res.status  = status;
		return r;
	endfunction

	// Values lean toward the rails and the threshold, where the compares flip.
	function automatic logic [VALUE_BITS-1:0] rand_value();
		case ($urandom_range(7))
			0: return '0;
			1: return FULL;
			2: return thr_reg + VALUE_BITS'($urandom_range(2)) - VALUE_BITS'(1);
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [DUR_BITS-1:0] rand_duration();
		case ($urandom_range(9))
			0: return '0;
			1: return DUR_FULL;
			2, 3, 4: return DUR_BITS'($urandom_range(1, 100));
			default: return DUR_BITS'($urandom);
		endcase
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Clock and watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		for (int n = 0; n < CYCLE_LIMIT; n++)
			@(posedge clk);
		$error("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
			expected_stats.size());
		$display("FAIL time_weighted_sample_statistics");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Monitors: sample at the edge, before any bench update lands
	// ------------------------------------------------------------------------

	// Track register writes in the local model.
	always @(posedge clk) begin
		if (cfg_bus.valid && cfg_bus.ready) begin
			case (cfg_bus.index)
				CFG_THRESHOLD: thr_reg  = cfg_bus.data;
				CFG_USE_MAX:   max_mode = cfg_bus.data[0];
				default: ;
			endcase
		end
	end

	// Run each accepted item beat through the model and queue what it yields.
	always @(posedge clk) begin : item_monitor
		stats_item_t   it;
		stats_result_t res;
		directed_row_t row;
		bit            has_res;
		if (item_bus.valid && item_bus.ready) begin
			it.value   = item_bus.value;
			it.dur     = item_bus.sample_duration;
			it.empty   = item_bus.empty_sample;
			it.s_end   = item_bus.sample_end;
			it.set_end = item_bus.set_end;
			has_res = stats_accept(it, res);
			// a directed row with a hand-written result replaces the model's one
			if (fixed_stats.size() != 0) begin
				row = fixed_stats.pop_front();
				if (row.fixed) res = row.res;
			end
			if (has_res) expected_stats.push_back(res);
		end
	end

	// Compare each result beat with the oldest expected one.
	always @(posedge clk) begin : result_monitor
		stats_result_t want;
		if (result_bus.valid && result_bus.ready) begin
			if (expected_stats.size() == 0) begin
				$error("result beat with no result expected");
				mismatches++;
			end else begin
				want = expected_stats.pop_front();
				check_field("min_value", want.min_v, result_bus.min_value);
				check_field("max_value", want.max_v, result_bus.max_value);
				check_field("weighted_metric", want.wmetric, result_bus.weighted_metric);
				check_field("violation_fraction", want.vfrac, result_bus.violation_fraction);
				check_field("status", want.status, result_bus.status);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------------
	initial begin : receiver
		int unsigned hold_left;
		int unsigned hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Offer one item beat after a random gap; return once it is taken.
	task automatic send_item(input stats_item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid           <= 1'b1;
		item_bus.value           <= it.value;
		item_bus.sample_duration <= it.dur;
		item_bus.empty_sample    <= it.empty;
		item_bus.sample_end      <= it.s_end;
		item_bus.set_end         <= it.set_end;
		do @(posedge clk); while (!item_bus.ready);
		items_sent++;
	endtask

	// Hold the register beat until taken; the caller drops valid after the last one.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	// Stop offering, wait for every expected result, then let the back settle.
	task automatic drain_results();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (expected_stats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random set: a few samples, mostly short, with the odd empty beat,
	// stray duration and set end that closes the sample on its own.
	task automatic send_random_set(input int unsigned max_vals);
		stats_item_t          it;
		logic [DUR_BITS-1:0]  dur;
		int unsigned          n_samp;
		int unsigned          n_vals;
		bit                   last;
		n_samp = $urandom_range(1, 5);
		for (int s = 0; s < n_samp; s++) begin
			n_vals = ($urandom_range(9) == 0) ? $urandom_range(7, max_vals)
				: $urandom_range(1, 6);
			dur = rand_duration();
			for (int v = 0; v < n_vals; v++) begin
				last       = (v == n_vals - 1);
				it.value   = rand_value();
				it.dur     = ($urandom_range(7) == 0 && !last) ? DUR_BITS'($urandom) : dur;
				it.empty   = ($urandom_range(59) == 0);
				it.s_end   = last;
				it.set_end = last && (s == n_samp - 1);
				if (it.set_end && $urandom_range(3) == 0)
					it.s_end = 1'b0;
				send_item(it);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		stats_item_t           it;
		logic [VALUE_BITS-1:0] thr;
		bit                    mode;
		int unsigned           phase_end;

		// drive every input from time zero
		arst_n                   = 1'b0;
		cfg_bus.valid            = 1'b0;
		cfg_bus.index            = CFG_THRESHOLD;
		cfg_bus.data             = '0;
		item_bus.valid           = 1'b0;
		item_bus.value           = '0;
		item_bus.sample_duration = '0;
		item_bus.empty_sample    = 1'b0;
		item_bus.sample_end      = 1'b0;
		item_bus.set_end         = 1'b0;
		mismatches    = 0;
		items_sent    = 0;
		hold_requests = 0;
		src_idle_pct  = 23;
		sink_idle_pct = 47;
		thr_reg  = '0;
		max_mode = 1'b1;
		stats_clear();

		// Directed sets under the reset settings (threshold 0, maximum mode).
		directed_rows = '{
			// a lone zero value with zero duration: nothing to weigh by
			mk_row('0, '0, 0, 0, 1, 1, '0, '0, '0, '0, STATUS_ZERO_DUR),
			// a set that is one empty sample; the value is ignored
			mk_row(FULL, DUR_FULL, 1, 1, 1, 1, '0, '0, '0, '0, STATUS_EMPTY),
			// full scale everywhere: every value violates, fraction clamps
			mk_row(FULL, DUR_FULL, 0, 0, 1, 1, FULL, FULL, FULL, FULL, STATUS_OK),
			// zero is not above a zero threshold
			mk_row('0, DUR_FULL, 0, 1, 1, 1, '0, '0, '0, '0, STATUS_OK),
			// mixed samples, last closed by a beat carrying both ends
			mk_row(16'h1234, 24'd5, 0, 0, 0, 0, '0, '0, '0, '0, STATUS_OK),
			mk_row(FULL, 24'd5, 0, 0, 0, 0, '0, '0, '0, '0, STATUS_OK),
			mk_row(16'h0001, 24'd7, 0, 1, 0, 0, '0, '0, '0, '0, STATUS_OK),
			mk_row(16'h8000, 24'd3, 0, 1, 0, 0, '0, '0, '0, '0, STATUS_OK),
			mk_row(16'h00FF, 24'hABCDEF, 0, 1, 1, 0, '0, '0, '0, '0, STATUS_OK),
			// an empty beat that closes an open sample still flags the set
			mk_row(16'd10, 24'd4, 0, 0, 0, 0, '0, '0, '0, '0, STATUS_OK),
			mk_row('0, 24'd9, 1, 1, 0, 0, '0, '0, '0, '0, STATUS_OK),
			mk_row(16'd20, 24'd6, 0, 1, 1, 1, '0, '0, '0, '0, STATUS_EMPTY),
			// a zero-duration sample next to a weighted one
			mk_row(16'h4000, '0, 0, 1, 0, 0, '0, '0, '0, '0, STATUS_OK),
			mk_row(16'hC000, 24'd2, 0, 0, 1, 0, '0, '0, '0, '0, STATUS_OK),
			// set end without sample end closes the last sample
			mk_row(16'h7FFF, 24'd1, 0, 1, 0, 0, '0, '0, '0, '0, STATUS_OK),
			mk_row(16'h8001, DUR_FULL, 0, 1, 0, 0, '0, '0, '0, '0, STATUS_OK),
			mk_row(16'h0F0F, 24'd3, 0, 0, 1, 0, '0, '0, '0, '0, STATUS_OK),
			// every sample of zero duration
			mk_row(16'd100, '0, 0, 1, 0, 0, '0, '0, '0, '0, STATUS_OK),
			mk_row(16'd200, '0, 0, 1, 1, 1, '0, '0, '0, '0, STATUS_ZERO_DUR)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			fixed_stats.push_back(directed_rows[i]);
			send_item(directed_rows[i].it);
		end
		drain_results();

		// Random phases: each writes the registers while the block is idle.
		for (int p = 0; p < N_PHASES; p++) begin
			src_idle_pct  = (p < 2) ? 23 : (p < 4) ? 47 : 0;
			sink_idle_pct = (p < 2) ? 47 : (p < 4) ? 23 : 0;
			case (p)
				0: thr = 16'h8000;
				1: thr = '0;
				2: thr = FULL;
				default: thr = VALUE_BITS'($urandom);
			endcase
			mode = (p % 2 == 0);
			write_reg(CFG_THRESHOLD, thr);
			write_reg(CFG_USE_MAX, {CFG_DATA_BITS'($urandom) << 1} | CFG_DATA_BITS'(mode));
			if (p == 4)
				write_reg(CFG_NONE, CFG_DATA_BITS'($urandom));
			cfg_bus.valid <= 1'b0;

			// Hold the receiver while short samples keep coming: the queue fills
			// and items stall. Then pause until every result is out.
			if (p == 1) begin
				hold_requests++;
				for (int k = 0; k < 48; k++) begin
					it.value   = VALUE_BITS'($urandom);
					it.dur     = DUR_BITS'($urandom_range(1, 1000));
					it.empty   = 1'b0;
					it.s_end   = 1'b1;
					it.set_end = (k % 4 == 3);
					send_item(it);
				end
				item_bus.valid <= 1'b0;
				@(posedge clk);
				while (expected_stats.size() != 0)
					@(posedge clk);
			end

			// One sample long enough to saturate the per-sample sum.
			if (p == 3) begin
				for (int k = 0; k < LONG_SAMPLE; k++) begin
					it.value   = VALUE_BITS'($urandom_range(62000, 65535));
					it.dur     = DUR_BITS'($urandom_range(1, 1 << 20));
					it.empty   = 1'b0;
					it.s_end   = (k == LONG_SAMPLE - 1);
					it.set_end = (k == LONG_SAMPLE - 1);
					send_item(it);
				end
			end

			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				send_random_set((p == 5) ? 40 : 12);
			drain_results();
		end

		if (mismatches == 0)
			$display("PASS time_weighted_sample_statistics");
		else
			$display("FAIL time_weighted_sample_statistics");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/tws_pkg.sv
rtl/tws_if.sv
rtl/tws_front.sv
rtl/tws_queue.sv
rtl/tws_div.sv
rtl/tws_back.sv
rtl/time_weighted_sample_statistics.sv
rtl/tws_checker.sv
bench/time_weighted_sample_statistics_tb.sv
